[rtl/fsp_pkg.sv]
// Shared types, constants and the arctangent table of the four-step phase pipeline.
// Depends on nothing; every other file of the block refers to it by scoped names.
`default_nettype none

package fsp_pkg;

	localparam int SAMPLE_W = 8;
	localparam int ANGLE_W = 16;
	localparam int DIFF_W = SAMPLE_W + 1;

	// Angle accumulator: Q30, wide enough for +/-(pi/2 + sum of table) plus rounding.
	localparam int Z_W = 34;
	localparam int Z_FRAC = 30;

	// Guard bits above the signed difference for CORDIC growth (about 1.65 * sqrt 2).
	localparam int XY_GUARD = 3;

	localparam int STAGE_LIMIT = 20;
	localparam int DEF_ANGLE_FRAC_BITS = 13;
	localparam int DEF_CORDIC_STAGES = 14;

	localparam longint PI_Q30 = 64'sd3373259426;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;

	// Items that bypass the CORDIC result.
	typedef enum logic [1:0] {
		SPEC_NONE,
		SPEC_ZERO,
		SPEC_PI
	} spec_t;

	// atan(2^-i) in Q30, truncated.
	function automatic logic signed [Z_W-1:0] atan_q30(input int idx);
		logic signed [Z_W-1:0] v;
		case (idx)
			0:       v = 34'sh3243F6A8;
			1:       v = 34'sh1DAC6705;
			2:       v = 34'sh0FADBAFC;
			3:       v = 34'sh07F56EA6;
			4:       v = 34'sh03FEAB76;
			5:       v = 34'sh01FFD55B;
			6:       v = 34'sh00FFFAAA;
			7:       v = 34'sh007FFF55;
			8:       v = 34'sh003FFFEA;
			9:       v = 34'sh001FFFFD;
			10:      v = 34'sh000FFFFF;
			11:      v = 34'sh0007FFFF;
			12:      v = 34'sh0003FFFF;
			13:      v = 34'sh0001FFFF;
			14:      v = 34'sh0000FFFF;
			15:      v = 34'sh00007FFF;
			16:      v = 34'sh00003FFF;
			17:      v = 34'sh00001FFF;
			18:      v = 34'sh00000FFF;
			19:      v = 34'sh000007FF;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

[rtl/fsp_if.sv]
// Valid/ready channel interfaces of the four-step phase pipeline: pixel items in, phase out.
// Depends on fsp_pkg for the field widths.
`default_nettype none

interface fsp_pixel_if;
	logic                          valid;
	logic                          ready;
	logic [fsp_pkg::SAMPLE_W-1:0]  sample_1;
	logic [fsp_pkg::SAMPLE_W-1:0]  sample_2;
	logic [fsp_pkg::SAMPLE_W-1:0]  sample_3;
	logic [fsp_pkg::SAMPLE_W-1:0]  sample_4;

	modport source (output valid, output sample_1, output sample_2, output sample_3,
		output sample_4, input ready);
	modport sink (input valid, input sample_1, input sample_2, input sample_3,
		input sample_4, output ready);
endinterface

interface fsp_phase_if;
	logic                                valid;
	logic                                ready;
	logic signed [fsp_pkg::ANGLE_W-1:0]  wrapped_angle;

	modport source (output valid, output wrapped_angle, input ready);
	modport sink (input valid, input wrapped_angle, output ready);
endinterface

`default_nettype wire

[rtl/four_step_wrapped_phase_unit.sv]
// Top level of the four-step wrapped phase pipeline.
// Depends on fsp_pkg, fsp_if, fsp_prerot, fsp_cordic_stage and fsp_round_out.
//
// Usage:
//   pixel: one item per pixel, the four gray samples of the four fringe images.
//   phase: one item per pixel, wrapped_angle = atan2(s4 - s2, s1 - s3) in radians,
//          signed, ANGLE_FRAC_BITS fraction bits, clamped to +/-pi.
//   Both channels are valid/ready; an item moves on a rising edge with both high.
// Pipeline: one pre-rotation stage, one stage per CORDIC iteration (capped at 20)
//   and one rounding/output stage.
// Throughput: one item per cycle while the output is not stalled, set by the
//   single iteration in each stage.
// Stall: each stage holds its item while the next one is full and stalled, and
//   accepts a new item into any empty slot, so bubbles close up; the final stage
//   is the output register, so results are held steady until taken.
// Reset: arst_n clears all valid bits at once; the block is ready as soon as
//   reset is released. No other state is kept.
`default_nettype none

module four_step_wrapped_phase_unit #(
	parameter int ANGLE_FRAC_BITS = fsp_pkg::DEF_ANGLE_FRAC_BITS,
	parameter int CORDIC_STAGES = fsp_pkg::DEF_CORDIC_STAGES
) (
	input wire logic   clk,
	input wire logic   arst_n,
	fsp_pixel_if.sink  pixel,
	fsp_phase_if.source phase
);

	localparam int NUM_STAGES = (CORDIC_STAGES > fsp_pkg::STAGE_LIMIT) ?
		fsp_pkg::STAGE_LIMIT : CORDIC_STAGES;
	localparam int XY_W = NUM_STAGES + fsp_pkg::DIFF_W + fsp_pkg::XY_GUARD;

	// Link k runs from the producer of stage k to its consumer; link 0 leaves the
	// pre-rotation stage, link NUM_STAGES feeds the output stage.
	logic                           valid_w [0:NUM_STAGES];
	logic                           ready_w [0:NUM_STAGES];
	logic signed [XY_W-1:0]         x_w     [0:NUM_STAGES];
	logic signed [XY_W-1:0]         y_w     [0:NUM_STAGES];
	logic signed [fsp_pkg::Z_W-1:0] z_w     [0:NUM_STAGES];
	fsp_pkg::spec_t                 spec_w  [0:NUM_STAGES];

	// Form differences, flag the zero and +pi cases, fold into the right half plane.
	fsp_prerot #(
		.CORDIC_STAGES (CORDIC_STAGES)
	) u_prerot (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pixel.valid),
		.in_ready  (pixel.ready),
		.sample_1  (pixel.sample_1),
		.sample_2  (pixel.sample_2),
		.sample_3  (pixel.sample_3),
		.sample_4  (pixel.sample_4),
		.out_valid (valid_w[0]),
		.out_ready (ready_w[0]),
		.out_x     (x_w[0]),
		.out_y     (y_w[0]),
		.out_z     (z_w[0]),
		.out_spec  (spec_w[0])
	);

	// One vectoring iteration per register stage.
	for (genvar k = 0; k < NUM_STAGES; k++) begin : g_cordic
		fsp_cordic_stage #(
			.CORDIC_STAGES (CORDIC_STAGES),
			.IDX           (k)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid_w[k]),
			.in_ready  (ready_w[k]),
			.in_x      (x_w[k]),
			.in_y      (y_w[k]),
			.in_z      (z_w[k]),
			.in_spec   (spec_w[k]),
			.out_valid (valid_w[k+1]),
			.out_ready (ready_w[k+1]),
			.out_x     (x_w[k+1]),
			.out_y     (y_w[k+1]),
			.out_z     (z_w[k+1]),
			.out_spec  (spec_w[k+1])
		);
	end

	// Round, clamp and saturate into the output register. The final x and y are
	// the vector magnitude and residue and are not needed.
	fsp_round_out #(
		.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
	) u_round_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_w[NUM_STAGES]),
		.in_ready  (ready_w[NUM_STAGES]),
		.in_z      (z_w[NUM_STAGES]),
		.in_spec   (spec_w[NUM_STAGES]),
		.out_valid (phase.valid),
		.out_ready (phase.ready),
		.out_angle (phase.wrapped_angle)
	);

endmodule

`default_nettype wire

[rtl/fsp_prerot.sv]
// First pipeline stage: sample differences, special-case detection, quarter-turn pre-rotation.
// Depends on fsp_pkg.
`default_nettype none

module fsp_prerot #(
	parameter int CORDIC_STAGES = fsp_pkg::DEF_CORDIC_STAGES,
	localparam int NUM_STAGES = (CORDIC_STAGES > fsp_pkg::STAGE_LIMIT) ?
		fsp_pkg::STAGE_LIMIT : CORDIC_STAGES,
	localparam int XY_W = NUM_STAGES + fsp_pkg::DIFF_W + fsp_pkg::XY_GUARD
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [fsp_pkg::SAMPLE_W-1:0]        sample_1,
	input  wire logic [fsp_pkg::SAMPLE_W-1:0]        sample_2,
	input  wire logic [fsp_pkg::SAMPLE_W-1:0]        sample_3,
	input  wire logic [fsp_pkg::SAMPLE_W-1:0]        sample_4,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed [XY_W-1:0]                   out_x,
	output logic signed [XY_W-1:0]                   out_y,
	output logic signed [fsp_pkg::Z_W-1:0]           out_z,
	output fsp_pkg::spec_t                           out_spec
);

	localparam logic signed [fsp_pkg::Z_W-1:0] HALF_PI_Z =
		fsp_pkg::Z_W'(fsp_pkg::HALF_PI_Q30);
	localparam int DIFF_MSB = fsp_pkg::DIFF_W - 1;

	logic signed [fsp_pkg::DIFF_W-1:0] dx;
	logic signed [fsp_pkg::DIFF_W-1:0] dy;
	logic signed [fsp_pkg::DIFF_W-1:0] xv;
	logic signed [fsp_pkg::DIFF_W-1:0] yv;
	logic signed [fsp_pkg::Z_W-1:0]    zv;
	fsp_pkg::spec_t                    spec;

	logic                              valid_s1;
	logic signed [XY_W-1:0]            x_s1;
	logic signed [XY_W-1:0]            y_s1;
	logic signed [fsp_pkg::Z_W-1:0]    z_s1;
	fsp_pkg::spec_t                    spec_s1;

	always_comb begin
		dx = $signed({1'b0, sample_1}) - $signed({1'b0, sample_3});
		dy = $signed({1'b0, sample_4}) - $signed({1'b0, sample_2});
		xv = dx;
		yv = dy;
		zv = '0;
		if (dx == '0 && dy == '0) begin
			spec = fsp_pkg::SPEC_ZERO;
		end else if (dy == '0 && dx[DIFF_MSB]) begin
			spec = fsp_pkg::SPEC_PI;
		end else begin
			spec = fsp_pkg::SPEC_NONE;
		end
		// Rotate the left half plane by a quarter turn into the right half plane.
		if (dx[DIFF_MSB] && !dy[DIFF_MSB]) begin
			xv = dy;
			yv = -dx;
			zv = HALF_PI_Z;
		end else if (dx[DIFF_MSB]) begin
			xv = -dy;
			yv = dx;
			zv = -HALF_PI_Z;
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			x_s1    <= {{fsp_pkg::XY_GUARD{xv[DIFF_MSB]}}, xv, {NUM_STAGES{1'b0}}};
			y_s1    <= {{fsp_pkg::XY_GUARD{yv[DIFF_MSB]}}, yv, {NUM_STAGES{1'b0}}};
			z_s1    <= zv;
			spec_s1 <= spec;
		end
	end

	assign out_valid = valid_s1;
	assign out_x     = x_s1;
	assign out_y     = y_s1;
	assign out_z     = z_s1;
	assign out_spec  = spec_s1;

endmodule

`default_nettype wire

[rtl/fsp_cordic_stage.sv]
// One registered CORDIC vectoring iteration with a fixed shift of IDX bits.
// Depends on fsp_pkg for the arctangent table and the accumulator width.
`default_nettype none

module fsp_cordic_stage #(
	parameter int CORDIC_STAGES = fsp_pkg::DEF_CORDIC_STAGES,
	parameter int IDX = 0,
	localparam int NUM_STAGES = (CORDIC_STAGES > fsp_pkg::STAGE_LIMIT) ?
		fsp_pkg::STAGE_LIMIT : CORDIC_STAGES,
	localparam int XY_W = NUM_STAGES + fsp_pkg::DIFF_W + fsp_pkg::XY_GUARD
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [XY_W-1:0]        in_x,
	input  wire logic signed [XY_W-1:0]        in_y,
	input  wire logic signed [fsp_pkg::Z_W-1:0] in_z,
	input  wire fsp_pkg::spec_t                in_spec,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [XY_W-1:0]             out_x,
	output logic signed [XY_W-1:0]             out_y,
	output logic signed [fsp_pkg::Z_W-1:0]     out_z,
	output fsp_pkg::spec_t                     out_spec
);

	localparam logic signed [fsp_pkg::Z_W-1:0] ATAN_I = fsp_pkg::atan_q30(IDX);

	logic signed [XY_W-1:0]         xs;
	logic signed [XY_W-1:0]         ys;
	logic signed [XY_W-1:0]         x_nx;
	logic signed [XY_W-1:0]         y_nx;
	logic signed [fsp_pkg::Z_W-1:0] z_nx;

	logic                           valid_s2;
	logic signed [XY_W-1:0]         x_s2;
	logic signed [XY_W-1:0]         y_s2;
	logic signed [fsp_pkg::Z_W-1:0] z_s2;
	fsp_pkg::spec_t                 spec_s2;

	always_comb begin
		xs = in_x >>> IDX;
		ys = in_y >>> IDX;
		// Rotate toward the x axis: direction follows the sign of y.
		if (!in_y[XY_W-1]) begin
			x_nx = in_x + ys;
			y_nx = in_y - xs;
			z_nx = in_z + ATAN_I;
		end else begin
			x_nx = in_x - ys;
			y_nx = in_y + xs;
			z_nx = in_z - ATAN_I;
		end
	end

	assign in_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			x_s2    <= x_nx;
			y_s2    <= y_nx;
			z_s2    <= z_nx;
			spec_s2 <= in_spec;
		end
	end

	assign out_valid = valid_s2;
	assign out_x     = x_s2;
	assign out_y     = y_s2;
	assign out_z     = z_s2;
	assign out_spec  = spec_s2;

endmodule

`default_nettype wire

[rtl/fsp_round_out.sv]
// Output stage: round the Q30 angle, clamp to +/-pi, saturate to 16 bits, apply special cases.
// Depends on fsp_pkg; its register is the output register of the block.
`default_nettype none

module fsp_round_out #(
	parameter int ANGLE_FRAC_BITS = fsp_pkg::DEF_ANGLE_FRAC_BITS
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic signed [fsp_pkg::Z_W-1:0]    in_z,
	input  wire fsp_pkg::spec_t                    in_spec,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic signed [fsp_pkg::ANGLE_W-1:0]     out_angle
);

	localparam int ZS_W = fsp_pkg::Z_W + 1;
	localparam int SHIFT = fsp_pkg::Z_FRAC - ANGLE_FRAC_BITS;
	localparam longint RND = longint'(1) << (SHIFT - 1);
	localparam longint PI_OUT = (fsp_pkg::PI_Q30 + RND) >>> SHIFT;
	localparam logic signed [ZS_W-1:0] RND_S = ZS_W'(RND);
	localparam logic signed [ZS_W-1:0] PI_S = ZS_W'(PI_OUT);
	localparam logic signed [ZS_W-1:0] NEG_PI_S = -PI_S;
	localparam logic signed [ZS_W-1:0] SAT_HI = ZS_W'((longint'(1) << (fsp_pkg::ANGLE_W - 1)) - 1);
	localparam logic signed [ZS_W-1:0] SAT_LO = -SAT_HI - ZS_W'(1);

	logic signed [ZS_W-1:0]             z_rnd;
	logic signed [ZS_W-1:0]             r;
	logic signed [ZS_W-1:0]             lim;
	logic signed [ZS_W-1:0]             sat;

	logic                               valid_s3;
	logic signed [fsp_pkg::ANGLE_W-1:0] angle_s3;

	always_comb begin
		z_rnd = $signed({in_z[fsp_pkg::Z_W-1], in_z}) + RND_S;
		r = z_rnd >>> SHIFT;
		case (in_spec)
			fsp_pkg::SPEC_ZERO: lim = '0;
			fsp_pkg::SPEC_PI:   lim = PI_S;
			default: begin
				if (r > PI_S) begin
					lim = PI_S;
				end else if (r < NEG_PI_S) begin
					lim = NEG_PI_S;
				end else begin
					lim = r;
				end
			end
		endcase
		if (lim > SAT_HI) begin
			sat = SAT_HI;
		end else if (lim < SAT_LO) begin
			sat = SAT_LO;
		end else begin
			sat = lim;
		end
	end

	assign in_ready = !valid_s3 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			angle_s3 <= sat[fsp_pkg::ANGLE_W-1:0];
		end
	end

	assign out_valid = valid_s3;
	assign out_angle = angle_s3;

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Testbench for four_step_wrapped_phase_unit: streams pixel items and checks every phase item
// against a CORDIC predictor of its own. Depends on fsp_pkg, fsp_if and the RTL of the block.
`timescale 1ns / 1ps

module tb_top;

	localparam int FRAC_BITS = fsp_pkg::DEF_ANGLE_FRAC_BITS;
	localparam int STAGES = fsp_pkg::DEF_CORDIC_STAGES;
	localparam int SW = fsp_pkg::SAMPLE_W;
	localparam int AW = fsp_pkg::ANGLE_W;
	localparam int RANDOM_ITEMS = 1750;
	localparam int CALM_TAIL = 150;
	localparam int HOLD_AFTER = 400;
	localparam int HOLD_CYCLES = 100;
	localparam int PRINT_LIMIT = 40;
	localparam longint CYCLE_LIMIT = 200000;

	// atan(2^-i) in Q30, truncated
	localparam longint ATAN_STEP [fsp_pkg::STAGE_LIMIT] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
		64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
		64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
		64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF
	};

	typedef struct {
		logic [SW-1:0] s1;
		logic [SW-1:0] s2;
		logic [SW-1:0] s3;
		logic [SW-1:0] s4;
	} pixel_item_t;

	typedef struct {
		pixel_item_t          pix;
		logic signed [AW-1:0] angle;
	} phase_expect_t;

	logic clk = 1'b0;
	logic arst_n;

	fsp_pixel_if pixel ();
	fsp_phase_if phase ();

	four_step_wrapped_phase_unit #(
		.ANGLE_FRAC_BITS(FRAC_BITS),
		.CORDIC_STAGES(STAGES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.pixel(pixel.sink),
		.phase(phase.source)
	);

	// 2 ns period
	always #1 clk = ~clk;

	pixel_item_t   pending_pixels [$];
	phase_expect_t expected_angles [$];

	int     total_items;
	int     accepted_count;
	int     received_count;
	int     mismatch_count;
	int     sender_idle_left;
	int     sink_stall_left;
	int     hold_left;
	logic   hold_done;
	longint cycle_count = 0;

	pixel_item_t   next_pixel;
	phase_expect_t new_expect;
	phase_expect_t got_expect;

	// Wrapped phase atan2(s4 - s2, s1 - s3) of one pixel, bit exact with the block.
	function automatic logic signed [AW-1:0] predict_phase(input logic [SW-1:0] s1,
		input logic [SW-1:0] s2, input logic [SW-1:0] s3, input logic [SW-1:0] s4);
		longint dx, dy, x, y, z, xs, ys, r, pi_out;
		int n_stages;
		dx = longint'(s1) - longint'(s3);
		dy = longint'(s4) - longint'(s2);
		pi_out = (fsp_pkg::PI_Q30 + (longint'(1) << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
		n_stages = (STAGES > fsp_pkg::STAGE_LIMIT) ? fsp_pkg::STAGE_LIMIT : STAGES;
		if (dx == 0 && dy == 0) begin
			r = 0;
		end else if (dy == 0 && dx < 0) begin
			r = pi_out;
		end else begin
			// Pre-rotate the left half plane by a quarter turn
			if (dx < 0 && dy >= 0) begin
				x = dy;
				y = -dx;
				z = fsp_pkg::HALF_PI_Q30;
			end else if (dx < 0) begin
				x = -dy;
				y = dx;
				z = -fsp_pkg::HALF_PI_Q30;
			end else begin
				x = dx;
				y = dy;
				z = 0;
			end
			x = x * (longint'(1) << n_stages);
			y = y * (longint'(1) << n_stages);
			for (int i = 0; i < n_stages; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y >= 0) begin
					x = x + ys;
					y = y - xs;
					z = z + ATAN_STEP[i];
				end else begin
					x = x - ys;
					y = y + xs;
					z = z - ATAN_STEP[i];
				end
			end
			r = (z + (longint'(1) << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
			if (r > pi_out)
				r = pi_out;
			if (r < -pi_out)
				r = -pi_out;
		end
		if (r > 32767)
			r = 32767;
		if (r < -32768)
			r = -32768;
		return r[AW-1:0];
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatch_count < PRINT_LIMIT)
			$display("MISMATCH @%0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic queue_pixel(input int s1, input int s2, input int s3, input int s4);
		pixel_item_t p;
		p.s1 = s1[SW-1:0];
		p.s2 = s2[SW-1:0];
		p.s3 = s3[SW-1:0];
		p.s4 = s4[SW-1:0];
		pending_pixels.insert(pending_pixels.size(), p);
	endtask

	// Random pixel: mostly free samples, plus zero differences, extremes and near misses.
	function automatic pixel_item_t random_pixel();
		pixel_item_t p;
		int kind;
		int delta;
		kind = $urandom_range(0, 9);
		p.s1 = SW'($urandom);
		p.s2 = SW'($urandom);
		p.s3 = SW'($urandom);
		p.s4 = SW'($urandom);
		case (kind)
			5: p.s3 = p.s1;
			6: p.s4 = p.s2;
			7: begin
				p.s3 = p.s1;
				p.s4 = p.s2;
			end
			8: begin
				p.s1 = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				p.s2 = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				p.s3 = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				p.s4 = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			end
			9: begin
				// small differences, where the angle is coarse and rounding matters
				delta = $urandom_range(0, 6) - 3;
				p.s3 = (int'(p.s1) + delta < 0 || int'(p.s1) + delta > 255) ? p.s1 :
					SW'(int'(p.s1) + delta);
				delta = $urandom_range(0, 6) - 3;
				p.s4 = (int'(p.s2) + delta < 0 || int'(p.s2) + delta > 255) ? p.s2 :
					SW'(int'(p.s2) + delta);
			end
			default: ;
		endcase
		return p;
	endfunction

	// Stimulus: directed corners first, then the random stream; wait for the drain.
	initial begin
		arst_n = 1'b0;

		// both differences zero
		queue_pixel(0, 0, 0, 0);
		queue_pixel(255, 255, 255, 255);
		// dy zero with dx negative: exactly +pi
		queue_pixel(0, 128, 255, 128);
		queue_pixel(100, 7, 101, 7);
		// positive real axis
		queue_pixel(255, 0, 0, 0);
		queue_pixel(1, 0, 0, 0);
		// imaginary axis, both signs, then one more with both differences zero
		queue_pixel(0, 255, 0, 0);
		queue_pixel(0, 0, 0, 255);
		queue_pixel(0, 1, 0, 0);
		queue_pixel(85, 170, 85, 170);
		// diagonal extremes in all four quadrants
		queue_pixel(255, 0, 0, 255);
		queue_pixel(255, 255, 0, 0);
		queue_pixel(0, 0, 255, 255);
		queue_pixel(0, 255, 255, 0);
		queue_pixel(0, 0, 1, 1);
		queue_pixel(0, 1, 1, 0);
		// close to the negative real axis, where the clamp to +/-pi acts; then near +x and two diagonals
		queue_pixel(0, 1, 255, 0);
		queue_pixel(0, 0, 255, 1);
		queue_pixel(255, 1, 0, 0);
		queue_pixel(170, 85, 85, 170);
		queue_pixel(85, 170, 170, 85);

		for (int n = 0; n < RANDOM_ITEMS; n++)
			pending_pixels.insert(pending_pixels.size(), random_pixel());
		total_items = pending_pixels.size();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (accepted_count != total_items)
			@(posedge clk);
		while (expected_angles.size() != 0)
			@(posedge clk);
		// let any stray item surface past the pipeline depth
		repeat (STAGES + 10) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

	// Driver: offer the next pending item whenever the slot is free, with idle bursts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel.valid <= 1'b0;
			sender_idle_left <= 0;
			accepted_count <= 0;
		end else begin
			// Predict every accepted item at the edge that moves it
			if (pixel.valid && pixel.ready) begin
				new_expect.pix.s1 = pixel.sample_1;
				new_expect.pix.s2 = pixel.sample_2;
				new_expect.pix.s3 = pixel.sample_3;
				new_expect.pix.s4 = pixel.sample_4;
				new_expect.angle = predict_phase(pixel.sample_1, pixel.sample_2,
					pixel.sample_3, pixel.sample_4);
				expected_angles.insert(expected_angles.size(), new_expect);
				accepted_count <= accepted_count + 1;
			end
			// Hold the current item until taken; only a free slot may change
			if (!pixel.valid || pixel.ready) begin
				if (sender_idle_left != 0) begin
					sender_idle_left <= sender_idle_left - 1;
					pixel.valid <= 1'b0;
				end else if (pending_pixels.size() == 0) begin
					pixel.valid <= 1'b0;
				end else if (accepted_count < total_items - CALM_TAIL && hold_left == 0 &&
					(accepted_count / 128) % 3 != 2 && $urandom_range(0, 5) == 0) begin
					// idle now and load a random burst length into sender_idle_left
					sender_idle_left <= $urandom_range(0, 3);
					pixel.valid <= 1'b0;
				end else begin
					next_pixel = pending_pixels.pop_front();
					pixel.valid <= 1'b1;
					pixel.sample_1 <= next_pixel.s1;
					pixel.sample_2 <= next_pixel.s2;
					pixel.sample_3 <= next_pixel.s3;
					pixel.sample_4 <= next_pixel.s4;
				end
			end
		end
	end

	// Long hold-off of the receiver, once, so the pipeline fills and stalls its input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && accepted_count >= HOLD_AFTER) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Monitor: check each taken phase item against the oldest prediction, then pick ready.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase.ready <= 1'b0;
			sink_stall_left <= 0;
			received_count <= 0;
		end else begin
			if (phase.valid && phase.ready) begin
				received_count <= received_count + 1;
				if (expected_angles.size() == 0) begin
					report_mismatch($sformatf("phase item %0d with nothing expected",
						phase.wrapped_angle));
				end else begin
					got_expect = expected_angles.pop_front();
					if (phase.wrapped_angle !== got_expect.angle)
						report_mismatch($sformatf(
							"samples %0d %0d %0d %0d: wrapped_angle %0d, expected %0d",
							got_expect.pix.s1, got_expect.pix.s2, got_expect.pix.s3,
							got_expect.pix.s4, phase.wrapped_angle, got_expect.angle));
				end
			end
			if (hold_left != 0) begin
				phase.ready <= 1'b0;
			end else if (sink_stall_left != 0) begin
				sink_stall_left <= sink_stall_left - 1;
				phase.ready <= 1'b0;
			end else if (accepted_count < total_items - CALM_TAIL &&
				(received_count / 100) % 3 != 1 && $urandom_range(0, 4) == 0) begin
				// stall now and load a random burst length into sink_stall_left
				sink_stall_left <= $urandom_range(0, 3);
				phase.ready <= 1'b0;
			end else begin
				phase.ready <= 1'b1;
			end
		end
	end

	// Drop the run if it hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

endmodule
